// ===== hw/rtl/bmw_pkg.sv =====
// Shared types and constants for the binary morphology window block.
package bmw_pkg;

	localparam int SE_SIZE_DEF    = 3;
	localparam int MAX_WIDTH_DEF  = 1024;
	localparam int MAX_HEIGHT_DEF = 1024;

	localparam int SIZE_CFG_W = 11;
	localparam int MODE_W     = 3;
	localparam int SE_PAT_W   = 18;
	localparam int SE_CODED   = SE_PAT_W / 2;
	localparam int MIN_SIZE   = 3;

	localparam int CFG_ADDR_W = 4;
	localparam int APB_DATA_W = 32;

	localparam logic [1:0] REG_IMAGE_WIDTH    = 2'd0;
	localparam logic [1:0] REG_IMAGE_HEIGHT   = 2'd1;
	localparam logic [1:0] REG_OPERATION_MODE = 2'd2;
	localparam logic [1:0] REG_SE_PATTERN     = 2'd3;

	localparam logic [MODE_W-1:0] MODE_EROSION    = 3'd0;
	localparam logic [MODE_W-1:0] MODE_DILATION   = 3'd1;
	localparam logic [MODE_W-1:0] MODE_HIT_MISS   = 3'd2;
	localparam logic [MODE_W-1:0] MODE_THINNING   = 3'd3;
	localparam logic [MODE_W-1:0] MODE_THICKENING = 3'd4;

	localparam logic [1:0] SE_MUST_ZERO = 2'd0;
	localparam logic [1:0] SE_MUST_ONE  = 2'd1;

	localparam logic [SIZE_CFG_W-1:0] IMAGE_WIDTH_RST    = 11'd1024;
	localparam logic [SIZE_CFG_W-1:0] IMAGE_HEIGHT_RST   = 11'd1024;
	localparam logic [MODE_W-1:0]     OPERATION_MODE_RST = MODE_EROSION;
	localparam logic [SE_PAT_W-1:0]   SE_PATTERN_RST     = 18'd174762;

	typedef struct packed {
		logic pixel_value;
		logic drain;
	} pixel_beat_t;

	typedef struct packed {
		logic out_pixel;
		logic frame_last;
	} result_beat_t;

endpackage

// ===== hw/rtl/bmw_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module bmw_ram #(
	parameter int WIDTH = 1,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

// ===== hw/rtl/bmw_cell.sv =====
// One window row: optional line delay from the row above plus the tap shift register.
module bmw_cell #(
	parameter int DEPTH    = 1024,
	parameter int SE_SIZE  = 3,
	parameter bit HAS_LINE = 1'b1
) (
	input  logic                     clk,
	input  logic                     en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	input  logic                     row_in,
	output logic [SE_SIZE-1:0]       row_win
);

	logic               cur;
	logic [SE_SIZE-2:0] taps_q;

	if (HAS_LINE) begin : g_line
		// delay of one image row: write slot ptr, read slot ptr+1 for the next beat
		bmw_ram #(
			.WIDTH (1),
			.DEPTH (DEPTH)
		) u_line (
			.clk     (clk),
			.wr_en   (en),
			.wr_addr (wr_addr),
			.wr_data (row_in),
			.rd_en   (en),
			.rd_addr (rd_addr),
			.rd_data (cur)
		);
	end else begin : g_direct
		assign cur = row_in;
	end

	if (SE_SIZE > 2) begin : g_shift
		always_ff @(posedge clk) begin
			if (en) begin
				taps_q <= {taps_q[SE_SIZE-3:0], cur};
			end
		end
	end else begin : g_single
		always_ff @(posedge clk) begin
			if (en) begin
				taps_q <= cur;
			end
		end
	end

	assign row_win = {taps_q, cur};

endmodule

// ===== hw/rtl/binary_morphology_window.sv =====
// Top level of the binary morphology window: config port, counters, window logic, output.
// One pixel beat is taken per clock unless stalled; a result beat is valid the cycle after
// the input beat that completes its window. The result for pixel p comes with input beat
// p+M*W+M, where M=(SE_SIZE-1)/2 and W is the row width, so after each frame the source
// sends M*W+M drain beats. The rate is set by the row cells, each line cell with one RAM
// write and read per beat, and by the combinational window evaluation. Line RAMs need no
// clearing after reset. Border pixels within M of an edge pass through (0 in hit-or-miss).
module binary_morphology_window #(
	parameter int SE_SIZE    = bmw_pkg::SE_SIZE_DEF,
	parameter int MAX_WIDTH  = bmw_pkg::MAX_WIDTH_DEF,
	parameter int MAX_HEIGHT = bmw_pkg::MAX_HEIGHT_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             psel,
	input  logic                             penable,
	input  logic                             pwrite,
	input  logic [bmw_pkg::CFG_ADDR_W-1:0]   paddr,
	input  logic [bmw_pkg::APB_DATA_W-1:0]   pwdata,
	output logic [bmw_pkg::APB_DATA_W-1:0]   prdata,
	output logic                             pready,
	input  logic                             pixel_valid,
	output logic                             pixel_stall,
	input  bmw_pkg::pixel_beat_t             pixel_beat,
	output logic                             result_valid,
	input  logic                             result_stall,
	output bmw_pkg::result_beat_t            result_beat
);

	import bmw_pkg::*;

	localparam int M  = (SE_SIZE - 1) / 2;
	localparam int N  = SE_SIZE * SE_SIZE;
	localparam int WW = $clog2(MAX_WIDTH + 1);
	localparam int HW = $clog2(MAX_HEIGHT + 1);
	localparam int AW = $clog2(MAX_WIDTH);
	localparam int PW = $clog2(MAX_WIDTH * (MAX_HEIGHT + SE_SIZE)) + 1;

	logic [SIZE_CFG_W-1:0] image_width_q;
	logic [SIZE_CFG_W-1:0] image_height_q;
	logic [MODE_W-1:0]     operation_mode_q;
	logic [SE_PAT_W-1:0]   se_pattern_q;
	logic                  cfg_wr;
	logic [1:0]            reg_sel;

	logic [WW-1:0] w;
	logic [HW-1:0] h;
	logic [PW-1:0] lag;

	logic          acc;
	logic          emit;
	logic          pix;
	logic [PW-1:0] in_pos_q;
	logic [HW-1:0] out_row_q;
	logic [WW-1:0] out_col_q;
	logic [AW-1:0] ptr_q;
	logic [AW:0]   ptr_inc;
	logic [AW-1:0] ptr_nxt;

	logic [SE_SIZE-1:0]              feed;
	logic [SE_SIZE-1:0][SE_SIZE-1:0] win;
	logic [N-1:0]                    v;
	logic [N-1:0]                    care1;
	logic [N-1:0]                    care0;
	logic                            cen;
	logic                            all_ones;
	logic                            any_one;
	logic                            hit;
	logic                            border;
	logic                            row_end;
	logic                            col_end;
	logic                            last;
	logic                            res;

	logic         result_valid_q;
	result_beat_t result_q;

	// configuration port
	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite;
	assign reg_sel = paddr[CFG_ADDR_W-1:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			image_width_q    <= IMAGE_WIDTH_RST;
			image_height_q   <= IMAGE_HEIGHT_RST;
			operation_mode_q <= OPERATION_MODE_RST;
			se_pattern_q     <= SE_PATTERN_RST;
		end else if (cfg_wr) begin
			case (reg_sel)
				REG_IMAGE_WIDTH: begin
					image_width_q <= pwdata[SIZE_CFG_W-1:0];
				end
				REG_IMAGE_HEIGHT: begin
					image_height_q <= pwdata[SIZE_CFG_W-1:0];
				end
				REG_OPERATION_MODE: begin
					operation_mode_q <= pwdata[MODE_W-1:0];
				end
				REG_SE_PATTERN: begin
					se_pattern_q <= pwdata[SE_PAT_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		case (reg_sel)
			REG_IMAGE_WIDTH:    prdata = APB_DATA_W'(image_width_q);
			REG_IMAGE_HEIGHT:   prdata = APB_DATA_W'(image_height_q);
			REG_OPERATION_MODE: prdata = APB_DATA_W'(operation_mode_q);
			REG_SE_PATTERN:     prdata = APB_DATA_W'(se_pattern_q);
			default:            prdata = '0;
		endcase
	end

	// saturated frame size
	always_comb begin
		if (image_width_q < SIZE_CFG_W'(MIN_SIZE)) begin
			w = WW'(MIN_SIZE);
		end else if (32'(image_width_q) > MAX_WIDTH) begin
			w = WW'(MAX_WIDTH);
		end else begin
			w = WW'(image_width_q);
		end
		if (image_height_q < SIZE_CFG_W'(MIN_SIZE)) begin
			h = HW'(MIN_SIZE);
		end else if (32'(image_height_q) > MAX_HEIGHT) begin
			h = HW'(MAX_HEIGHT);
		end else begin
			h = HW'(image_height_q);
		end
	end

	assign lag = PW'(w) * PW'(M) + PW'(M);

	// handshake
	assign pixel_stall  = result_valid_q && result_stall;
	assign acc          = pixel_valid && !pixel_stall;
	assign emit         = in_pos_q >= lag;
	assign pix          = pixel_beat.pixel_value & ~pixel_beat.drain;
	assign result_valid = result_valid_q;
	assign result_beat  = result_q;

	// shared line pointer, wraps at the row width
	assign ptr_inc = (AW + 1)'(ptr_q) + (AW + 1)'(1);
	assign ptr_nxt = (ptr_inc >= (AW + 1)'(w)) ? '0 : ptr_inc[AW-1:0];

	// chain of row cells; cell a sees the stream delayed by a rows
	for (genvar a = 0; a < SE_SIZE; a++) begin : g_row
		if (a == 0) begin : g_head
			assign feed[a] = pix;
		end else begin : g_link
			assign feed[a] = win[a-1][0];
		end

		bmw_cell #(
			.DEPTH    (MAX_WIDTH),
			.SE_SIZE  (SE_SIZE),
			.HAS_LINE (a > 0)
		) u_cell (
			.clk     (clk),
			.en      (acc),
			.wr_addr (ptr_q),
			.rd_addr (ptr_nxt),
			.row_in  (feed[a]),
			.row_win (win[a])
		);

		for (genvar b = 0; b < SE_SIZE; b++) begin : g_col
			localparam int K = (SE_SIZE - 1 - a) * SE_SIZE + (SE_SIZE - 1 - b);
			assign v[K] = win[a][b];
			if (K < SE_CODED) begin : g_coded
				assign care1[K] = se_pattern_q[2*K +: 2] == SE_MUST_ONE;
				assign care0[K] = se_pattern_q[2*K +: 2] == SE_MUST_ZERO;
			end else begin : g_free
				assign care1[K] = 1'b0;
				assign care0[K] = 1'b0;
			end
		end
	end

	assign cen      = win[M][M];
	assign all_ones = &(v | ~care1);
	assign any_one  = |(v & care1);
	assign hit      = &((v & care1) | (~v & care0) | ~(care1 | care0));

	assign border = (out_row_q < HW'(M)) ||
	                ((HW + 1)'(out_row_q) + (HW + 1)'(M) >= (HW + 1)'(h)) ||
	                (out_col_q < WW'(M)) ||
	                ((WW + 1)'(out_col_q) + (WW + 1)'(M) >= (WW + 1)'(w));
	assign row_end = (HW + 1)'(out_row_q) + (HW + 1)'(1) >= (HW + 1)'(h);
	assign col_end = (WW + 1)'(out_col_q) + (WW + 1)'(1) >= (WW + 1)'(w);
	assign last    = row_end && col_end;

	always_comb begin
		case (operation_mode_q)
			MODE_EROSION:    res = border ? cen : all_ones;
			MODE_DILATION:   res = border ? cen : any_one;
			MODE_HIT_MISS:   res = border ? 1'b0 : hit;
			MODE_THINNING:   res = border ? cen : (cen & ~hit);
			MODE_THICKENING: res = border ? cen : (cen | hit);
			default:         res = cen;
		endcase
	end

	// position counters; the line pointer restarts with each frame
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_pos_q  <= '0;
			out_row_q <= '0;
			out_col_q <= '0;
			ptr_q     <= '0;
		end else if (acc) begin
			ptr_q <= (emit && last) ? '0 : ptr_nxt;
			if (!emit) begin
				in_pos_q <= in_pos_q + PW'(1);
			end else if (last) begin
				in_pos_q  <= '0;
				out_row_q <= '0;
				out_col_q <= '0;
			end else begin
				in_pos_q <= in_pos_q + PW'(1);
				if (col_end) begin
					out_col_q <= '0;
					out_row_q <= out_row_q + HW'(1);
				end else begin
					out_col_q <= out_col_q + WW'(1);
				end
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (acc && emit) begin
			result_valid_q <= 1'b1;
		end else if (!result_stall) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (acc && emit) begin
			result_q.out_pixel  <= res;
			result_q.frame_last <= last;
		end
	end

	a_frame_restart: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && emit && last) |=> (in_pos_q == '0 && out_row_q == '0 && out_col_q == '0))
		else $error("counters not cleared after last beat of frame");

	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid_q) |-> $past(acc && emit))
		else $error("result beat without a completing input beat");

	a_idle_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!acc |=> ($stable(in_pos_q) && $stable(ptr_q)))
		else $error("position or line pointer moved without an input beat");

endmodule

// ===== dv/tb_top.sv =====
// Self-checking testbench for binary_morphology_window: random raster frames, every mode.
`timescale 1ns / 1ps

module tb_top;
	import bmw_pkg::*;

	localparam int SE_N       = SE_SIZE_DEF;
	localparam int MARGIN     = (SE_N - 1) / 2;
	localparam int HIST_DEPTH = (SE_N - 1) * MAX_WIDTH_DEF + SE_N;

	localparam logic [1:0]        SE_DONT_CARE   = 2'd3;
	localparam logic [MODE_W-1:0] MODE_UNUSED_HI = 3'd7;

	class morph_scoreboard;
		logic [SIZE_CFG_W-1:0] width_reg;
		logic [SIZE_CFG_W-1:0] height_reg;
		logic [MODE_W-1:0]     mode_reg;
		logic [SE_PAT_W-1:0]   pattern_reg;
		bit                    history [HIST_DEPTH];
		int unsigned           in_pos;
		int unsigned           out_row;
		int unsigned           out_col;
		result_beat_t          expected_pixels [$];
		int                    mismatches;

		function new();
			width_reg   = IMAGE_WIDTH_RST;
			height_reg  = IMAGE_HEIGHT_RST;
			mode_reg    = OPERATION_MODE_RST;
			pattern_reg = SE_PATTERN_RST;
			in_pos      = 0;
			out_row     = 0;
			out_col     = 0;
			mismatches  = 0;
		endfunction

		function void log_mismatch(string msg);
			mismatches++;
			if (mismatches <= 10) $display("[%0t] %s", $time, msg);
		endfunction

		function void write_reg(logic [1:0] idx, logic [APB_DATA_W-1:0] data);
			case (idx)
				REG_IMAGE_WIDTH:    width_reg   = data[SIZE_CFG_W-1:0];
				REG_IMAGE_HEIGHT:   height_reg  = data[SIZE_CFG_W-1:0];
				REG_OPERATION_MODE: mode_reg    = data[MODE_W-1:0];
				default:            pattern_reg = data[SE_PAT_W-1:0];
			endcase
		endfunction

		function int unsigned clamp_dim(logic [SIZE_CFG_W-1:0] v, int unsigned hi);
			if (v < MIN_SIZE) return MIN_SIZE;
			if (v > hi) return hi;
			return v;
		endfunction

		function int unsigned eff_width();
			return clamp_dim(width_reg, MAX_WIDTH_DEF);
		endfunction

		function int unsigned eff_height();
			return clamp_dim(height_reg, MAX_HEIGHT_DEF);
		endfunction

		function int unsigned frame_lag();
			return MARGIN * eff_width() + MARGIN;
		endfunction

		function bit hist_bit(longint pos);
			if (pos < 0) return 1'b0;
			return history[pos % HIST_DEPTH];
		endfunction

		function bit window_result(longint ctr, int unsigned r, int unsigned c,
				int unsigned w, int unsigned h);
			bit         cen, all_ones, any_one, hit, v;
			logic [1:0] code;
			int         dr, dc, k;
			cen = hist_bit(ctr);
			if (mode_reg > MODE_THICKENING) return cen;
			if (r < MARGIN || r + MARGIN >= h || c < MARGIN || c + MARGIN >= w)
				return (mode_reg == MODE_HIT_MISS) ? 1'b0 : cen;
			all_ones = 1'b1;
			any_one  = 1'b0;
			hit      = 1'b1;
			for (dr = -MARGIN; dr <= MARGIN; dr++) begin
				for (dc = -MARGIN; dc <= MARGIN; dc++) begin
					k    = (dr + MARGIN) * SE_N + dc + MARGIN;
					code = (k < SE_CODED) ? pattern_reg[2*k +: 2] : SE_DONT_CARE;
					v    = hist_bit(ctr + dr * longint'(w) + dc);
					if (code == SE_MUST_ONE) begin
						if (v) any_one = 1'b1;
						else all_ones = 1'b0;
					end
					if ((code == SE_MUST_ZERO || code == SE_MUST_ONE) && v != code[0])
						hit = 1'b0;
				end
			end
			case (mode_reg)
				MODE_EROSION:  return all_ones;
				MODE_DILATION: return any_one;
				MODE_HIT_MISS: return hit;
				MODE_THINNING: return hit ? 1'b0 : cen;
				default:       return cen | hit;
			endcase
		endfunction

		function void take_pixel(pixel_beat_t b);
			int unsigned  w, h, lag, t, r, c;
			bit           last;
			result_beat_t want;
			w   = eff_width();
			h   = eff_height();
			lag = frame_lag();
			t   = in_pos;
			history[t % HIST_DEPTH] = b.drain ? 1'b0 : b.pixel_value;
			if (t < lag) begin
				in_pos = t + 1;
				return;
			end
			r = out_row;
			c = out_col;
			want.out_pixel  = window_result(longint'(t) - longint'(lag), r, c, w, h);
			last            = (r + 1 >= h) && (c + 1 >= w);
			want.frame_last = last;
			if (last) begin
				in_pos  = 0;
				out_row = 0;
				out_col = 0;
			end else begin
				in_pos = t + 1;
				if (c + 1 >= w) begin
					out_col = 0;
					out_row = r + 1;
				end else begin
					out_col = c + 1;
				end
			end
			expected_pixels.push_back(want);
		endfunction

		function void check_result(result_beat_t got);
			result_beat_t want;
			if (expected_pixels.size() == 0) begin
				log_mismatch($sformatf("unexpected result beat: out_pixel %0b frame_last %0b",
					got.out_pixel, got.frame_last));
				return;
			end
			want = expected_pixels.pop_front();
			if (got.out_pixel !== want.out_pixel || got.frame_last !== want.frame_last)
				log_mismatch($sformatf("out_pixel exp %0b got %0b, frame_last exp %0b got %0b",
					want.out_pixel, got.out_pixel, want.frame_last, got.frame_last));
		endfunction
	endclass

	logic                  clk          = 1'b0;
	logic                  arst_n       = 1'b0;
	logic                  psel         = 1'b0;
	logic                  penable      = 1'b0;
	logic                  pwrite       = 1'b0;
	logic [CFG_ADDR_W-1:0] paddr        = '0;
	logic [APB_DATA_W-1:0] pwdata       = '0;
	logic [APB_DATA_W-1:0] prdata;
	logic                  pready;
	logic                  pixel_valid  = 1'b0;
	logic                  pixel_stall;
	pixel_beat_t           pixel_beat   = '0;
	logic                  result_valid;
	logic                  result_stall = 1'b0;
	result_beat_t          result_beat;

	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int hold_left     = 0;

	morph_scoreboard sb;

	binary_morphology_window dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready),
		.pixel_valid  (pixel_valid),
		.pixel_stall  (pixel_stall),
		.pixel_beat   (pixel_beat),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result_beat  (result_beat)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// receiver: random stalls, plus long hold-offs counted down here
	always @(posedge clk) begin
		if (hold_left > 0) begin
			result_stall <= 1'b1;
			hold_left--;
		end else begin
			result_stall <= ($urandom_range(99) < recv_idle_pct);
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (pixel_valid && !pixel_stall) sb.take_pixel(pixel_beat);
			if (result_valid && !result_stall) sb.check_result(result_beat);
		end
	end

	function automatic logic [APB_DATA_W-1:0] reg_mask(logic [1:0] idx);
		case (idx)
			REG_IMAGE_WIDTH, REG_IMAGE_HEIGHT: return (1 << SIZE_CFG_W) - 1;
			REG_OPERATION_MODE:                return (1 << MODE_W) - 1;
			default:                           return (1 << SE_PAT_W) - 1;
		endcase
	endfunction

	// write, then read back; unused upper bits sometimes carry junk
	task automatic set_reg(logic [1:0] idx, logic [APB_DATA_W-1:0] value);
		logic [APB_DATA_W-1:0] mask, data;
		mask = reg_mask(idx);
		data = value & mask;
		if ($urandom_range(1)) data = data | ($urandom & ~mask);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= data;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		sb.write_reg(idx, data);
		pwrite  <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (prdata !== (data & mask))
			sb.log_mismatch($sformatf("reg %0d readback exp %0h got %0h",
				idx, data & mask, prdata));
		psel    <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	// wait on the clock first so the beat just taken is already in the scoreboard
	task automatic settle();
		@(posedge clk);
		while (sb.expected_pixels.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic send_pixel(pixel_beat_t b);
		while ($urandom_range(99) < send_idle_pct) begin
			pixel_valid <= 1'b0;
			@(posedge clk);
		end
		pixel_valid <= 1'b1;
		pixel_beat  <= b;
		do @(posedge clk); while (pixel_stall);
	endtask

	// one frame of body pixels followed by the drain beats that flush it
	task automatic send_frame(int density, int drain_pct, bit pause_mid);
		int unsigned body, total, i;
		pixel_beat_t b;
		body  = sb.eff_width() * sb.eff_height();
		total = body + sb.frame_lag();
		for (i = 0; i < total; i++) begin
			if (i < body) begin
				b.drain       = ($urandom_range(99) < drain_pct);
				b.pixel_value = ($urandom_range(99) < density);
			end else begin
				b.drain       = 1'b1;
				b.pixel_value = $urandom_range(1);
			end
			send_pixel(b);
			if (pause_mid && i == body / 2) begin
				pixel_valid <= 1'b0;
				settle();
			end
		end
		pixel_valid <= 1'b0;
	endtask

	task automatic random_config(int shape);
		logic [APB_DATA_W-1:0] w, h, m, p;
		int                    k, sel;
		case (shape)
			1: begin
				w = 40;
				h = 2;
			end
			2: begin
				w = 3;
				h = 40;
			end
			default: begin
				sel = $urandom_range(9);
				w   = (sel == 0) ? $urandom_range(2) : (sel == 1) ? $urandom_range(11, 24)
					: $urandom_range(3, 10);
				sel = $urandom_range(9);
				h   = (sel == 0) ? $urandom_range(2) : $urandom_range(3, 8);
			end
		endcase
		m = ($urandom_range(9) < 8) ? $urandom_range(4) : $urandom_range(5, 7);
		case ($urandom_range(5))
			0: p = '0;
			1: p = (1 << SE_PAT_W) - 1;
			2: p = $urandom;
			default: begin
				p = '0;
				for (k = 0; k < SE_CODED; k++) begin
					sel = $urandom_range(9);
					p[2*k +: 2] = (sel < 3) ? SE_MUST_ONE : (sel < 5) ? SE_MUST_ZERO
						: {1'b1, 1'($urandom_range(1))};
				end
			end
		endcase
		set_reg(REG_IMAGE_WIDTH, w);
		set_reg(REG_IMAGE_HEIGHT, h);
		set_reg(REG_OPERATION_MODE, m);
		set_reg(REG_SE_PATTERN, p);
	endtask

	initial begin
		int unsigned sent;
		int          phase, fcount, shape;
		sb = new();
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// smallest frame (sizes below minimum), all-ones window must hit
		set_reg(REG_IMAGE_WIDTH, 0);
		set_reg(REG_IMAGE_HEIGHT, 1);
		set_reg(REG_OPERATION_MODE, MODE_HIT_MISS);
		set_reg(REG_SE_PATTERN, 18'h15555);
		send_frame(100, 0, 1'b0);
		settle();
		// unused mode passes pixels through; drain beats inside the frame
		set_reg(REG_OPERATION_MODE, MODE_UNUSED_HI);
		set_reg(REG_SE_PATTERN, 0);
		send_frame(50, 30, 1'b0);
		settle();

		for (phase = 0; phase < 3; phase++) begin
			send_idle_pct = (phase == 0) ? 14 : (phase == 1) ? 66 : 0;
			recv_idle_pct = (phase == 0) ? 66 : (phase == 1) ? 14 : 0;
			sent   = 0;
			fcount = 0;
			while (sent < 650) begin
				shape = (fcount == 0 && phase == 0) ? 1 : (fcount == 0 && phase == 2) ? 2 : 0;
				random_config(shape);
				if (fcount == 1) hold_left = 300;
				sent += sb.eff_width() * sb.eff_height() + sb.frame_lag();
				send_frame($urandom_range(10, 90), 3, fcount == 2);
				settle();
				fcount++;
			end
		end

		settle();
		if (sb.mismatches == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

	initial begin
		#5_000_000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

// ===== binary_morphology_window.f =====
hw/rtl/bmw_pkg.sv
hw/rtl/bmw_ram.sv
hw/rtl/bmw_cell.sv
hw/rtl/binary_morphology_window.sv
dv/tb_top.sv
